// ===== rtl/rasr_pkg.sv =====
// ----------------------------------------------------------------------------
// rasr_pkg
// Shared types and constants of the rational add, subtract and reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package rasr_pkg;

  localparam int unsigned WIDTH_DEFAULT = 32;

  // Result field widths.
  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 31;

  typedef enum logic [1:0] {
    CMD_REDUCE  = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_SUB     = 2'd2,
    CMD_COMPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Control between the sequencer and the divider.
  typedef struct packed {
    logic go;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rasr_div.sv =====
// ----------------------------------------------------------------------------
// rasr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rasr_div #(
  parameter int unsigned W = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rasr_pkg::div_req_t  req,
  input  wire logic [W-1:0]        dividend,
  input  wire logic [W-1:0]        divisor,
  output rasr_pkg::div_stat_t      stat,
  output logic [W-1:0]             quotient,
  output logic [W-1:0]             remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  dvs;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] count;
  logic          busy;
  logic          done;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem, quo[W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.go && !busy) begin
        busy  <= 1'b1;
        count <= CW'(W);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        if (trial[W]) begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without work");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && count != CW'(1) |=> busy) else $error("divider stopped early");

endmodule

`default_nettype wire

// ===== rtl/rational_add_sub_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_add_sub_reduce
// Reduce, add, subtract and compare signed fractions, one shared divider.
// ----------------------------------------------------------------------------
// Usage: present command and the four operand fields with start high while
// busy is low. That edge accepts the transaction, and busy rises the next
// cycle. All division runs through one 64-bit restoring divider (one
// quotient bit per cycle) under a small sequencer. Every gcd step, every
// division by a gcd and every lcm scaling is one pass of it. One 32 by 32
// multiplier forms the lcm and the two scaled numerators.
// Latency depends on the operands. Each Euclid step is one divider pass.
// A reduce runs one Euclid loop plus two divider passes, so its length
// grows with the number of Euclid steps. An add or subtract runs four
// Euclid loops plus nine divider passes. A zero denominator or an operand
// out of range goes from the check step straight to the output step.
// When the transaction is finished, done pulses for one cycle with
// result_numerator, result_denominator, is_equal and status valid in that
// cycle. Busy falls at the same edge, so the next transaction can be
// accepted at the edge that ends the done cycle. The receiver cannot stall:
// a result not taken in its cycle is gone. Reset clears the sequencer and
// the divider control, but the result registers are not cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_sub_reduce #(
  parameter int unsigned WIDTH = rasr_pkg::WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   command,
  input  wire logic signed [31:0]           left_numerator,
  input  wire logic signed [31:0]           left_denominator,
  input  wire logic signed [31:0]           right_numerator,
  input  wire logic signed [31:0]           right_denominator,
  output logic                              done,
  output logic signed [31:0]                result_numerator,
  output logic [30:0]                       result_denominator,
  output logic                              is_equal,
  output logic [1:0]                        status
);

  // Internal magnitudes are 64 bits wide so that every product stays exact.
  localparam int unsigned DW = 64;
  localparam logic [DW-1:0] WMAX = (DW'(1) << (WIDTH - 1)) - DW'(1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CHECK  = 14'b00000000000010,
    S_GCD    = 14'b00000000000100,
    S_GCDW   = 14'b00000000001000,
    S_DIVN   = 14'b00000000010000,
    S_DIVNW  = 14'b00000000100000,
    S_DIVD   = 14'b00000001000000,
    S_DIVDW  = 14'b00000010000000,
    S_RED    = 14'b00000100000000,
    S_LCM    = 14'b00001000000000,
    S_SCALEA = 14'b00010000000000,
    S_SCALEB = 14'b00100000000000,
    S_SUM    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  // Which reduction is in flight: left, right or the final sum.
  typedef enum logic [1:0] {
    R_LEFT  = 2'd0,
    R_RIGHT = 2'd1,
    R_SUM   = 2'd2
  } red_t;

  state_t state;
  red_t   which;
  logic [1:0] cmd;

  logic signed [DW-1:0] ln, ld, rn, rd;   // operands, sign extended
  logic [DW-1:0] mn, md;                   // magnitudes under reduction
  logic          neg;                      // sign of the value under reduction
  logic [DW-1:0] ga, gb;                   // Euclid pair
  logic [DW-1:0] an, ad, bn, bd;           // reduced magnitudes
  logic          aneg, bneg;
  logic [DW-1:0] lcm;
  logic signed [DW-1:0] sa, sb;
  logic          mul_phase;
  logic [DW-1:0] prod;
  logic [DW-1:0] res_n, res_d;
  logic          res_neg, eq;
  logic [1:0]    st;

  rasr_pkg::div_req_t  dreq;
  rasr_pkg::div_stat_t dstat;
  logic [DW-1:0] dvd, dvs, quo, rem;

  rasr_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .dividend(dvd), .divisor(dvs),
    .stat(dstat), .quotient(quo), .remainder(rem)
  );

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic fits(input logic signed [DW-1:0] v);
    fits = (v >= -$signed(WMAX) - 64'sd1) && (v <= $signed(WMAX));
  endfunction

  // Magnitude fits as a signed WIDTH-bit value of the given sign.
  function automatic logic mfits(input logic [DW-1:0] m, input logic ng);
    mfits = ng ? (m <= WMAX + DW'(1)) : (m <= WMAX);
  endfunction

  function automatic logic signed [DW-1:0] signed_of(input logic [DW-1:0] m,
                                                      input logic ng);
    signed_of = ng ? -$signed(m) : $signed(m);
  endfunction

  logic signed [DW-1:0] s_sum;
  logic ovf_add;
  always_comb begin
    s_sum   = sa + sb;
    ovf_add = (sa[DW-1] == sb[DW-1]) && (s_sum[DW-1] != sa[DW-1]);
  end

  // Shared multiplier. Operands come from 32-bit inputs, so reduced parts
  // and the quotients that scale them never exceed 2^31 and fit 32 bits.
  logic [31:0]   mul_a, mul_b;
  logic [DW-1:0] mul_p;
  always_comb begin
    mul_a = quo[31:0];
    case (state)
      S_LCM:    mul_b = bd[31:0];
      S_SCALEA: mul_b = an[31:0];
      default:  mul_b = bn[31:0];
    endcase
    mul_p = DW'(mul_a) * DW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      dreq.go  <= 1'b0;
      mul_phase <= 1'b0;
    end else begin
      done    <= 1'b0;
      dreq.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= command;
            ln    <= DW'(left_numerator);
            ld    <= DW'(left_denominator);
            rn    <= DW'(right_numerator);
            rd    <= DW'(right_denominator);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          st <= rasr_pkg::ST_OK;
          eq <= 1'b0;
          if (ld == '0 || (cmd != rasr_pkg::CMD_REDUCE && rd == '0)) begin
            st    <= rasr_pkg::ST_ZERO_DEN;
            state <= S_OUT;
          end else if (!fits(ln) || !fits(ld) ||
                       (cmd != rasr_pkg::CMD_REDUCE && (!fits(rn) || !fits(rd)))) begin
            st    <= rasr_pkg::ST_OVERFLOW;
            state <= S_OUT;
          end else begin
            which <= R_LEFT;
            mn    <= mag(ln);
            md    <= mag(ld);
            neg   <= ln[DW-1] ^ ld[DW-1];
            ga    <= mag(ln);
            gb    <= mag(ld);
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // Euclid: when gb is zero, ga holds the gcd.
          if (gb == '0) begin
            dvd     <= mn;
            dvs     <= ga;
            dreq.go <= 1'b1;
            state   <= S_DIVNW;
          end else begin
            dvd     <= ga;
            dvs     <= gb;
            dreq.go <= 1'b1;
            state   <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (dstat.done) begin
            ga    <= gb;
            gb    <= rem;
            state <= S_GCD;
          end
        end
        S_DIVNW: begin
          if (dstat.done) begin
            mn      <= quo;
            dvd     <= md;
            dreq.go <= 1'b1;
            state   <= S_DIVDW;
          end
        end
        S_DIVDW: begin
          if (dstat.done) begin
            md    <= quo;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (md > WMAX || !mfits(mn, neg && mn != '0)) begin
            st    <= rasr_pkg::ST_OVERFLOW;
            state <= S_OUT;
          end else begin
            case (which)
              R_LEFT: begin
                an   <= mn;
                ad   <= md;
                aneg <= neg && mn != '0;
                if (cmd == rasr_pkg::CMD_REDUCE) begin
                  res_n   <= mn;
                  res_d   <= md;
                  res_neg <= neg && mn != '0;
                  state   <= S_OUT;
                end else begin
                  which <= R_RIGHT;
                  mn    <= mag(rn);
                  md    <= mag(rd);
                  neg   <= rn[DW-1] ^ rd[DW-1];
                  ga    <= mag(rn);
                  gb    <= mag(rd);
                  state <= S_GCD;
                end
              end
              R_RIGHT: begin
                bn   <= mn;
                bd   <= md;
                bneg <= (neg && mn != '0) ^ (cmd == rasr_pkg::CMD_SUB);
                if (cmd == rasr_pkg::CMD_COMPARE) begin
                  res_n   <= an;
                  res_d   <= ad;
                  res_neg <= aneg;
                  eq      <= (an == mn) && (ad == md) && (aneg == (neg && mn != '0));
                  state   <= S_OUT;
                end else begin
                  // gcd of the two denominators, then lcm = ad / g * bd.
                  ga    <= ad;
                  gb    <= md;
                  state <= S_DIVN;
                end
              end
              default: begin
                res_n   <= mn;
                res_d   <= md;
                res_neg <= neg && mn != '0;
                state   <= S_OUT;
              end
            endcase
          end
        end
        S_DIVN: begin
          if (gb == '0) begin
            dvd     <= ad;
            dvs     <= ga;
            dreq.go <= 1'b1;
            state   <= S_LCM;
          end else begin
            dvd     <= ga;
            dvs     <= gb;
            dreq.go <= 1'b1;
            state   <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (dstat.done) begin
            ga    <= gb;
            gb    <= rem;
            state <= S_DIVN;
          end
        end
        S_LCM: begin
          // Multiply step: ad/g times bd, then scale factors by division.
          if (dstat.done && !mul_phase) begin
            prod      <= mul_p;
            mul_phase <= 1'b1;
          end else if (mul_phase) begin
            mul_phase <= 1'b0;
            lcm       <= prod;
            dvd       <= prod;
            dvs       <= ad;
            dreq.go   <= 1'b1;
            state     <= S_SCALEA;
          end
        end
        S_SCALEA: begin
          if (dstat.done && !mul_phase) begin
            prod      <= mul_p;
            mul_phase <= 1'b1;
          end else if (mul_phase) begin
            mul_phase <= 1'b0;
            sa        <= signed_of(prod, aneg);
            dvd       <= lcm;
            dvs       <= bd;
            dreq.go   <= 1'b1;
            state     <= S_SCALEB;
          end
        end
        S_SCALEB: begin
          if (dstat.done && !mul_phase) begin
            prod      <= mul_p;
            mul_phase <= 1'b1;
          end else if (mul_phase) begin
            mul_phase <= 1'b0;
            sb        <= signed_of(prod, bneg && bn != '0);
            state     <= S_SUM;
          end
        end
        S_SUM: begin
          if (!fits(lcm) || !fits(sa) || !fits(sb) || ovf_add || !fits(s_sum)) begin
            st    <= rasr_pkg::ST_OVERFLOW;
            state <= S_OUT;
          end else begin
            which <= R_SUM;
            mn    <= mag(s_sum);
            md    <= lcm;
            neg   <= s_sum[DW-1];
            ga    <= mag(s_sum);
            gb    <= lcm;
            state <= S_GCD;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          // The result must also fit the 32-bit numerator and 31-bit denominator fields.
          if (st == rasr_pkg::ST_OK &&
              (res_n > (res_neg ? 64'h80000000 : 64'h7FFFFFFF) ||
               res_d > 64'h7FFFFFFF)) begin
            st <= rasr_pkg::ST_OVERFLOW;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic ok_out;
  assign ok_out = (st == rasr_pkg::ST_OK);

  assign busy               = (state != S_IDLE);
  assign result_numerator   = ok_out ? 32'(signed_of(res_n, res_neg)) : '0;
  assign result_denominator = ok_out ? res_d[30:0] : '0;
  assign is_equal           = ok_out && eq;
  assign status             = st;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_done_prev_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OUT) else $error("done without output step");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction lost");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != rasr_pkg::ST_OK |-> result_denominator == '0)
    else $error("error result carries denominator");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.go |-> !dstat.busy) else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== test/rational_add_sub_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_tb
// Self-checking bench for the rational reduce, add, subtract and compare block.
// Directed corner transactions come first, then random transactions under
// several idling phases. A behavioral fraction model predicts every result,
// and a monitor compares each done pulse with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_sub_reduce_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 64'd100000000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               eq;
    rasr_pkg::status_t  st;
  } fraction_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         command;
  logic signed [31:0] left_numerator;
  logic signed [31:0] left_denominator;
  logic signed [31:0] right_numerator;
  logic signed [31:0] right_denominator;
  logic               done;
  logic signed [31:0] result_numerator;
  logic [30:0]        result_denominator;
  logic               is_equal;
  logic [1:0]         status;

  fraction_result_t pending_results[$];
  int               mismatch_count;
  int               unexpected_count;
  longint           cycle_count;
  int               sender_idle_pct;

  rational_add_sub_reduce dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .command            (command),
    .left_numerator     (left_numerator),
    .left_denominator   (left_denominator),
    .right_numerator    (right_numerator),
    .right_denominator  (right_denominator),
    .done               (done),
    .result_numerator   (result_numerator),
    .result_denominator (result_denominator),
    .is_equal           (is_equal),
    .status             (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Euclid on magnitudes. Magnitudes here never exceed 2^63.
  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Bring n/d to lowest terms with a positive denominator. Returns 0 when a
  // part leaves the 32-bit signed range.
  function automatic bit lowest_terms(longint n, longint d, output longint rn,
                                      output longint rd);
    longint unsigned mn, md, g;
    bit neg;
    mn = abs_of(n);
    md = abs_of(d);
    g = gcd_of(mn, md);
    mn = mn / g;
    md = md / g;
    neg = ((n < 0) != (d < 0)) && (mn != 0);
    rn = 0;
    rd = 0;
    if (md > 64'd2147483647) return 1'b0;
    if (neg ? (mn > 64'd2147483648) : (mn > 64'd2147483647)) return 1'b0;
    rn = neg ? -longint'(mn) : longint'(mn);
    rd = longint'(md);
    return 1'b1;
  endfunction

  function automatic bit in_range(longint v);
    return (v >= I32_MIN) && (v <= I32_MAX);
  endfunction

  // Expected outcome of one transaction. The block holds no state.
  function automatic fraction_result_t predict_fraction(rasr_pkg::cmd_t cmd,
      logic signed [31:0] ln, logic signed [31:0] ld, logic signed [31:0] rn,
      logic signed [31:0] rd);
    fraction_result_t r;
    longint an, ad, bn, bd, resn, resd, g, l, sa, sb, s;
    bit ok;
    r = '0;
    r.st = rasr_pkg::ST_OK;
    an = 0; ad = 0; bn = 0; bd = 0; resn = 0; resd = 0;
    if (ld == 0 || (cmd != rasr_pkg::CMD_REDUCE && rd == 0)) begin
      r.st = rasr_pkg::ST_ZERO_DEN;
      return r;
    end
    ok = lowest_terms(ln, ld, an, ad);
    if (ok && cmd != rasr_pkg::CMD_REDUCE) ok = lowest_terms(rn, rd, bn, bd);
    if (ok && (cmd == rasr_pkg::CMD_REDUCE || cmd == rasr_pkg::CMD_COMPARE)) begin
      resn = an;
      resd = ad;
      r.eq = (cmd == rasr_pkg::CMD_COMPARE) && (an == bn) && (ad == bd);
    end else if (ok) begin
      g = longint'(gcd_of(ad, bd));
      l = (ad / g) * bd;
      if (cmd == rasr_pkg::CMD_SUB) bn = -bn;
      sa = (l / ad) * an;
      sb = (l / bd) * bn;
      ok = in_range(l) && in_range(sa) && in_range(sb);
      if (ok) begin
        s = sa + sb;
        ok = in_range(s) && lowest_terms(s, l, resn, resd);
      end
    end
    if (!ok) begin
      r.st = rasr_pkg::ST_OVERFLOW;
      r.eq = 1'b0;
      return r;
    end
    r.num = resn[31:0];
    r.den = resd[30:0];
    return r;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  // Present one transaction at the falling edge and hold it until an edge
  // with busy low takes it. Start stays high on return so that the next
  // transaction can follow at once; an idle gap or a wait drops it.
  task automatic send_fraction(rasr_pkg::cmd_t cmd, logic signed [31:0] ln,
                               logic signed [31:0] ld, logic signed [31:0] rn,
                               logic signed [31:0] rd);
    if (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      idle_cycles($urandom_range(12, 1));
    end
    start             <= 1'b1;
    command           <= cmd;
    left_numerator    <= ln;
    left_denominator  <= ld;
    right_numerator   <= rn;
    right_denominator <= rd;
    pending_results.push_back(predict_fraction(cmd, ln, ld, rn, rd));
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Random operand value with a weighting toward small and boundary values.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9, 0))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3, 4, 5: return $signed($urandom_range(24, 0)) - 12;
      6, 7: return $signed($urandom_range(2000, 0)) - 1000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] pick_denominator();
    // Zero denominators appear, but rarely.
    if ($urandom_range(39, 0) == 0) return 32'sd0;
    return pick_value();
  endfunction

  task automatic test_directed_corners();
    send_fraction(rasr_pkg::CMD_REDUCE, 6, 8, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, -6, -8, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 6, -8, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 0, -5, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 7, 0, 1, 1);
    send_fraction(rasr_pkg::CMD_REDUCE, 32'sh8000_0000, 1, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 32'sh8000_0000, -1, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 1, 32'sh8000_0000, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    send_fraction(rasr_pkg::CMD_REDUCE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    send_fraction(rasr_pkg::CMD_ADD, 1, 2, 1, 3);
    send_fraction(rasr_pkg::CMD_ADD, 1, 2, -1, 2);
    send_fraction(rasr_pkg::CMD_ADD, 32'sh7FFF_FFFF, 1, 1, 1);
    send_fraction(rasr_pkg::CMD_ADD, 1, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFE);
    send_fraction(rasr_pkg::CMD_ADD, 1, 2, 1, 0);
    send_fraction(rasr_pkg::CMD_SUB, 3, 4, 1, 4);
    send_fraction(rasr_pkg::CMD_SUB, 32'sh8000_0000, 1, 1, 1);
    send_fraction(rasr_pkg::CMD_SUB, 0, 1, 32'sh8000_0000, 1);
    send_fraction(rasr_pkg::CMD_SUB, 5, 6, 5, 6);
    send_fraction(rasr_pkg::CMD_COMPARE, 2, 4, -3, -6);
    send_fraction(rasr_pkg::CMD_COMPARE, 2, 4, 3, 5);
    send_fraction(rasr_pkg::CMD_COMPARE, 0, 3, 0, -7);
    send_fraction(rasr_pkg::CMD_COMPARE, 1, 1, 1, 0);
    send_fraction(rasr_pkg::CMD_COMPARE, 32'sh8000_0000, -1, 1, 1);
    wait_all_results();
  endtask

  // Mostly well-formed operands with random content; occasional zero
  // denominators and extreme values reach the error paths.
  task automatic test_random_phase(int count, int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      send_fraction(rasr_pkg::cmd_t'($urandom_range(3, 0)), pick_value(),
                    pick_denominator(), pick_value(), pick_denominator());
      // Let the pipeline drain completely now and then.
      if ($urandom_range(99, 0) == 0) wait_all_results();
    end
    wait_all_results();
    sender_idle_pct = 0;
  endtask

  // A monitor samples every done pulse at the rising edge and checks it
  // against the oldest prediction.
  always @(posedge clk) begin
    fraction_result_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("Unexpected result num=%0d den=%0d eq=%0b st=%0d",
                   result_numerator, result_denominator, is_equal, status);
      end else begin
        want = pending_results.pop_front();
        if (result_numerator !== want.num || result_denominator !== want.den ||
            is_equal !== want.eq || status !== want.st) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10) begin
            $display("Mismatch: expected num=%0d den=%0d eq=%0b st=%0d",
                     want.num, want.den, want.eq, want.st);
            $display("          got      num=%0d den=%0d eq=%0b st=%0d",
                     result_numerator, result_denominator, is_equal, status);
          end
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = rasr_pkg::CMD_REDUCE;
    left_numerator = '0;
    left_denominator = '0;
    right_numerator = '0;
    right_denominator = '0;
    mismatch_count = 0;
    unexpected_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_random_phase(400, 0);
    test_random_phase(400, 77);
    // The receiver can never stall, so the stall phases only vary the sender.
    test_random_phase(400, 0);
    test_random_phase(400, 26);

    wait_all_results();
    idle_cycles(DRAIN_CYCLES);
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
